// ===== hw/rtl/morton_cell_hash_top_defines.svh =====
// ----------------------------------------------------------------------------
// morton_cell_hash_top_defines: assertion macros
// Clocked implication checks shared by the port-level checker.
// ----------------------------------------------------------------------------
`ifndef MORTON_CELL_HASH_TOP_DEFINES_SVH
`define MORTON_CELL_HASH_TOP_DEFINES_SVH

// Same-cycle implication, ignored while reset is asserted.
`define MCH_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mch assertion failed");

// Next-cycle implication, ignored while reset is asserted.
`define MCH_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mch assertion failed");

// Next-cycle implication that also holds across reset.
`define MCH_ASSERT_NEXT_RST(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("mch assertion failed");

`endif

// ===== hw/rtl/mch_pkg.sv =====
// ----------------------------------------------------------------------------
// mch_pkg: shared types and constants
// Widths, mix constants and the words handed between pipeline cells.
// ----------------------------------------------------------------------------
package mch_pkg;

    localparam int AXIS_BITS   = 21;
    localparam int POS_W       = 32;
    localparam int CELL_W      = 31;
    localparam int TABLE_W     = 25;
    localparam int BUCKET_W    = 24;
    localparam int CODE_W      = 64;
    localparam int DIV_STEPS   = POS_W;
    localparam int MOD_STEPS   = CODE_W;
    localparam int SUM_W       = POS_W + 2;

    localparam logic [SUM_W-1:0] CELL_OFFSET   = SUM_W'(1) << (AXIS_BITS - 1);
    localparam logic [SUM_W-1:0] AXIS_CELL_TOP = (SUM_W'(1) << AXIS_BITS) - SUM_W'(1);

    localparam logic [63:0] MIX_MULT  = 64'h9e3779b97f4a7c15;
    localparam int          MIX_SHIFT = 32;

    localparam logic [TABLE_W-1:0] TABLE_LIMIT = TABLE_W'(1) << BUCKET_W;

    // configuration register indexes
    localparam logic CFG_CELL_SIZE  = 1'b0;
    localparam logic CFG_TABLE_SIZE = 1'b1;

    // one axis inside the divider chain
    typedef struct packed {
        logic              neg;
        logic [CELL_W-1:0] rem;
        logic [POS_W-1:0]  dq;
    } t_div_lane;

    typedef struct packed {
        t_div_lane [2:0] lane;
    } t_div_word;

    // word inside the modulo chain
    typedef struct packed {
        logic                clamped;
        logic [BUCKET_W-1:0] rem;
        logic [CODE_W-1:0]   dq;
    } t_mod_word;

endpackage

// ===== hw/rtl/mch_div_cell.sv =====
// ----------------------------------------------------------------------------
// mch_div_cell: one restoring division step
// Retires one quotient bit per axis and hands the word to the next cell.
// ----------------------------------------------------------------------------
module mch_div_cell
    import mch_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic [CELL_W-1:0] i_div,
    input  logic              i_valid,
    input  t_div_word         i_word,
    output logic              o_valid,
    output t_div_word         o_word
);

    logic      r_valid;
    t_div_word r_word;
    t_div_word n_word;

    // shift in one dividend bit, subtract when it fits
    always_comb begin
        logic [POS_W-1:0] t;
        logic [POS_W-1:0] d;
        d      = {1'b0, i_div};
        n_word = i_word;
        for (int a = 0; a < 3; a++) begin
            t = {i_word.lane[a].rem, i_word.lane[a].dq[POS_W-1]};
            if (t >= d) begin
                n_word.lane[a].rem = CELL_W'(t - d);
                n_word.lane[a].dq  = {i_word.lane[a].dq[POS_W-2:0], 1'b1};
            end else begin
                n_word.lane[a].rem = t[CELL_W-1:0];
                n_word.lane[a].dq  = {i_word.lane[a].dq[POS_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

// ===== hw/rtl/mch_mod_cell.sv =====
// ----------------------------------------------------------------------------
// mch_mod_cell: one restoring remainder step
// Folds one code bit into the running remainder by the table size.
// ----------------------------------------------------------------------------
module mch_mod_cell
    import mch_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic [TABLE_W-1:0] i_mod,
    input  logic               i_valid,
    input  t_mod_word          i_word,
    output logic               o_valid,
    output t_mod_word          o_word
);

    logic      r_valid;
    t_mod_word r_word;
    t_mod_word n_word;

    // remainder stays below the modulus, so 24 bits hold it
    always_comb begin
        logic [TABLE_W-1:0] t;
        t      = {i_word.rem, i_word.dq[CODE_W-1]};
        n_word = i_word;
        n_word.dq = {i_word.dq[CODE_W-2:0], 1'b0};
        if (t >= i_mod) begin
            n_word.rem = BUCKET_W'(t - i_mod);
        end else begin
            n_word.rem = t[BUCKET_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

// ===== hw/rtl/mch_mix.sv =====
// ----------------------------------------------------------------------------
// mch_mix: cell index, Morton interleave and mixing
// Three stages: floor/offset/clamp, interleave/partial products, sum/xor-shift.
// ----------------------------------------------------------------------------
module mch_mix
    import mch_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  logic      i_valid,
    input  t_div_word i_word,
    output logic      o_valid,
    output t_mod_word o_word
);

    logic [2:0]                       r_valid;
    logic [2:0][AXIS_BITS-1:0]        r_cell;
    logic [2:0][AXIS_BITS-1:0]        n_cell;
    logic                             r_clamp1, r_clamp2, r_clamp3;
    logic                             n_clamp;
    logic [63:0]                      r_p0;
    logic [31:0]                      r_p1, r_p2;
    logic [63:0]                      n_code, n_m1, n_p0, n_m, n_m2;
    logic [31:0]                      n_p1, n_p2;
    logic [63:0]                      r_m2;

    // stage 1: floor quotient, offset, clamp to the axis range
    always_comb begin
        logic [SUM_W-1:0] q;
        logic [SUM_W-1:0] s;
        n_clamp = 1'b0;
        for (int a = 0; a < 3; a++) begin
            q = {2'b00, i_word.lane[a].dq};
            if (i_word.lane[a].neg) begin
                q = SUM_W'(0) - q - SUM_W'(i_word.lane[a].rem != '0);
            end
            s = q + CELL_OFFSET;
            if (s[SUM_W-1]) begin
                n_cell[a] = '0;
                n_clamp   = 1'b1;
            end else if (s > AXIS_CELL_TOP) begin
                n_cell[a] = '1;
                n_clamp   = 1'b1;
            end else begin
                n_cell[a] = s[AXIS_BITS-1:0];
            end
        end
    end

    // stage 2: interleave, fold high half, low 64 bits of the product in parts
    always_comb begin
        n_code = '0;
        for (int b = 0; b < AXIS_BITS; b++) begin
            n_code[3*b]     = r_cell[0][b];
            n_code[3*b + 1] = r_cell[1][b];
            n_code[3*b + 2] = r_cell[2][b];
        end
        n_m1 = n_code ^ (n_code >> MIX_SHIFT);
        n_p0 = 64'(n_m1[31:0] * MIX_MULT[31:0]);
        n_p1 = 32'(n_m1[31:0] * MIX_MULT[63:32]);
        n_p2 = 32'(n_m1[63:32] * MIX_MULT[31:0]);
    end

    // stage 3: sum partial products, final xor-shift
    always_comb begin
        n_m  = r_p0 + {32'(r_p1 + r_p2), 32'h0};
        n_m2 = n_m ^ (n_m >> MIX_SHIFT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cell   <= n_cell;
            r_clamp1 <= n_clamp;
            r_p0     <= n_p0;
            r_p1     <= n_p1;
            r_p2     <= n_p2;
            r_clamp2 <= r_clamp1;
            r_m2     <= n_m2;
            r_clamp3 <= r_clamp2;
        end
    end

    assign o_valid        = r_valid[2];
    assign o_word.clamped = r_clamp3;
    assign o_word.rem     = '0;
    assign o_word.dq      = r_m2;

endmodule

// ===== hw/rtl/morton_cell_hash_top.sv =====
// ----------------------------------------------------------------------------
// morton_cell_hash_top: 3D Morton spatial hash
// Position in, bucket index and clamp flag out, fully pipelined.
// ----------------------------------------------------------------------------
// One word is accepted per cycle unless a stalled result word holds the
// whole pipe. Each result passes a chain of 32 divider cells (one quotient
// bit per cell, all three axes side by side), three stages of clamp,
// interleave and mixing with the 64-bit multiply split into 32x32 partial
// products, then a chain of 64 remainder cells, one code bit per cell.
// Configuration must be written only while the pipe is empty.
module morton_cell_hash_top
    import mch_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [CELL_W-1:0]   i_cfg_data,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic signed [POS_W-1:0] i_pos_x,
    input  logic signed [POS_W-1:0] i_pos_y,
    input  logic signed [POS_W-1:0] i_pos_z,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [BUCKET_W-1:0] o_bucket,
    output logic                o_clamped
);

    logic [CELL_W-1:0]  r_cell_size;
    logic [TABLE_W-1:0] r_table_size;
    logic [CELL_W-1:0]  w_div;
    logic [TABLE_W-1:0] w_mod;
    logic               w_en;

    t_div_word               w_div_in;
    t_div_word [DIV_STEPS:0] w_div_word;
    logic      [DIV_STEPS:0] w_div_valid;
    t_mod_word [MOD_STEPS:0] w_mod_word;
    logic      [MOD_STEPS:0] w_mod_valid;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_size  <= CELL_W'(65536);
            r_table_size <= TABLE_W'(65536);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CELL_SIZE:  r_cell_size  <= i_cfg_data;
                CFG_TABLE_SIZE: r_table_size <= i_cfg_data[TABLE_W-1:0];
                default: ;
            endcase
        end
    end

    // effective divisor and modulus
    assign w_div = (r_cell_size == '0) ? CELL_W'(1) : r_cell_size;
    always_comb begin
        if (r_table_size == '0) begin
            w_mod = TABLE_W'(1);
        end else if (r_table_size > TABLE_LIMIT) begin
            w_mod = TABLE_LIMIT;
        end else begin
            w_mod = r_table_size;
        end
    end

    // global hold while the result word is stalled
    assign w_en    = !(o_valid && i_stall);
    assign o_stall = o_valid && i_stall;

    // divider entry: sign and magnitude of each axis
    always_comb begin
        w_div_in.lane[0].neg = i_pos_x[POS_W-1];
        w_div_in.lane[1].neg = i_pos_y[POS_W-1];
        w_div_in.lane[2].neg = i_pos_z[POS_W-1];
        w_div_in.lane[0].dq  = i_pos_x[POS_W-1] ? POS_W'(-i_pos_x) : i_pos_x;
        w_div_in.lane[1].dq  = i_pos_y[POS_W-1] ? POS_W'(-i_pos_y) : i_pos_y;
        w_div_in.lane[2].dq  = i_pos_z[POS_W-1] ? POS_W'(-i_pos_z) : i_pos_z;
        for (int a = 0; a < 3; a++) begin
            w_div_in.lane[a].rem = '0;
        end
    end

    assign w_div_word[0]  = w_div_in;
    assign w_div_valid[0] = i_valid;

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
        mch_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_div   (w_div),
            .i_valid (w_div_valid[g]),
            .i_word  (w_div_word[g]),
            .o_valid (w_div_valid[g+1]),
            .o_word  (w_div_word[g+1])
        );
    end

    mch_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_div_valid[DIV_STEPS]),
        .i_word  (w_div_word[DIV_STEPS]),
        .o_valid (w_mod_valid[0]),
        .o_word  (w_mod_word[0])
    );

    for (genvar g = 0; g < MOD_STEPS; g++) begin : g_mod
        mch_mod_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_mod   (w_mod),
            .i_valid (w_mod_valid[g]),
            .i_word  (w_mod_word[g]),
            .o_valid (w_mod_valid[g+1]),
            .o_word  (w_mod_word[g+1])
        );
    end

    assign o_valid   = w_mod_valid[MOD_STEPS];
    assign o_bucket  = w_mod_word[MOD_STEPS].rem;
    assign o_clamped = w_mod_word[MOD_STEPS].clamped;

endmodule

// ===== hw/rtl/mch_checker.sv =====
// ----------------------------------------------------------------------------
// mch_checker: port-level assertions
// Watches the top level handshakes and result word over time.
// ----------------------------------------------------------------------------
`include "morton_cell_hash_top_defines.svh"

module mch_checker
    import mch_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_stall,
    input logic                o_valid,
    input logic                i_stall,
    input logic [BUCKET_W-1:0] o_bucket,
    input logic                o_clamped
);

    // a stalled result word holds
    `MCH_ASSERT_NEXT(a_hold, o_valid && i_stall, o_valid && $stable(o_bucket) && $stable(o_clamped))

    // input is held back only while a result is waiting
    `MCH_ASSERT_NOW(a_stall_src, o_stall, o_valid && i_stall)

    // reset empties the pipe
    `MCH_ASSERT_NEXT_RST(a_reset, !i_rst_n, !o_valid)

endmodule

bind morton_cell_hash_top mch_checker u_mch_checker (.*);

// ===== sim/morton_cell_hash_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// morton_cell_hash_checker: result predictor and scoreboard
// Watches the position and result channels, computes the expected bucket and
// clamp flag of every accepted position, and compares them in order.
// ----------------------------------------------------------------------------
module morton_cell_hash_checker
    import mch_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic                    i_cfg_index,
    input  logic [CELL_W-1:0]       i_cfg_data,
    input  logic                    i_in_valid,
    input  logic                    i_in_stall,
    input  logic signed [POS_W-1:0] i_pos_x,
    input  logic signed [POS_W-1:0] i_pos_y,
    input  logic signed [POS_W-1:0] i_pos_z,
    input  logic                    i_out_valid,
    input  logic                    i_out_stall,
    input  logic [BUCKET_W-1:0]     i_bucket,
    input  logic                    i_clamped,
    output int                      o_errors,
    output int                      o_pending,
    output int                      o_results,
    output int                      o_clamp_hits
);

    typedef struct packed {
        logic [BUCKET_W-1:0] bucket;
        logic                clamped;
    } t_hash_word;

    logic [CELL_W-1:0]  cell_size_q;
    logic [TABLE_W-1:0] table_size_q;
    t_hash_word         hash_q[$];

    // Floor-divided, offset and saturated cell index of one axis.
    function automatic logic [AXIS_BITS-1:0] cell_index(input logic signed [POS_W-1:0] pos,
                                                        input longint div, inout logic hit);
        longint p, q;
        p = longint'(pos);
        q = p / div;
        if ((p % div) != 0 && p < 0) q = q - 1;
        q = q + (longint'(1) << (AXIS_BITS - 1));
        if (q < 0) begin
            hit = 1'b1;
            q = 0;
        end else if (q > (longint'(1) << AXIS_BITS) - 1) begin
            hit = 1'b1;
            q = (longint'(1) << AXIS_BITS) - 1;
        end
        return q[AXIS_BITS-1:0];
    endfunction

    function automatic t_hash_word hash_position(input logic signed [POS_W-1:0] px,
                                                 input logic signed [POS_W-1:0] py,
                                                 input logic signed [POS_W-1:0] pz);
        longint               div;
        logic [63:0]          modv, m;
        logic                 hit;
        logic [AXIS_BITS-1:0] cx, cy, cz;
        t_hash_word           w;
        div  = (cell_size_q == 0) ? 1 : longint'(cell_size_q);
        modv = (table_size_q == 0) ? 64'd1 : 64'(table_size_q);
        if (modv > 64'(TABLE_LIMIT)) modv = 64'(TABLE_LIMIT);
        hit = 1'b0;
        cx = cell_index(px, div, hit);
        cy = cell_index(py, div, hit);
        cz = cell_index(pz, div, hit);
        m = '0;
        for (int b = 0; b < AXIS_BITS; b++) begin
            m[3*b]   = cx[b];
            m[3*b+1] = cy[b];
            m[3*b+2] = cz[b];
        end
        m = m ^ (m >> 32);
        m = m * 64'h9e3779b97f4a7c15;
        m = m ^ (m >> 32);
        w.bucket  = BUCKET_W'(m % modv);
        w.clamped = hit;
        return w;
    endfunction

    assign o_pending = hash_q.size();

    // Register writes, predictions and in-order comparison.
    always @(posedge i_clk) begin
        t_hash_word want;
        if (!i_rst_n) begin
            cell_size_q  <= CELL_W'(65536);
            table_size_q <= TABLE_W'(65536);
            hash_q.delete();
            o_errors     <= 0;
            o_results    <= 0;
            o_clamp_hits <= 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_CELL_SIZE) cell_size_q <= i_cfg_data;
                else table_size_q <= i_cfg_data[TABLE_W-1:0];
            end
            if (i_in_valid && !i_in_stall)
                hash_q.insert(hash_q.size(), hash_position(i_pos_x, i_pos_y, i_pos_z));
            if (i_out_valid && !i_out_stall) begin
                o_results <= o_results + 1;
                if (hash_q.size() == 0) begin
                    $error("result word with no position pending");
                    o_errors <= o_errors + 1;
                end else begin
                    want = hash_q.pop_front();
                    if (want.clamped) o_clamp_hits <= o_clamp_hits + 1;
                    if (i_bucket !== want.bucket || i_clamped !== want.clamped)
                        o_errors <= o_errors + 1;
                    if (i_bucket !== want.bucket)
                        $error("bucket: expected %0d, got %0d", want.bucket, i_bucket);
                    if (i_clamped !== want.clamped)
                        $error("clamped: expected %0b, got %0b", want.clamped, i_clamped);
                end
            end
        end
    end

endmodule

// ===== sim/morton_cell_hash_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// morton_cell_hash_top_tb: spatial hash block testbench
// Drives positions through several cell and table settings with bursty input
// and random output stalls; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module morton_cell_hash_top_tb;
    import mch_pkg::*;

    localparam int PIPE_CYCLES = 99;
    localparam int IDLE_LIMIT  = 2000;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_we = 1'b0;
    logic                    i_cfg_index = CFG_CELL_SIZE;
    logic [CELL_W-1:0]       i_cfg_data = '0;
    logic                    i_valid = 1'b0;
    logic                    o_stall;
    logic signed [POS_W-1:0] i_pos_x = '0, i_pos_y = '0, i_pos_z = '0;
    logic                    o_valid;
    logic                    i_stall = 1'b0;
    logic [BUCKET_W-1:0]     o_bucket;
    logic                    o_clamped;
    int                      errors, pending, results, clamp_hits;
    int                      idle_cycles = 0;
    int                      sent = 0;
    logic                    stall_mode = 1'b0;
    logic                    stim_done = 1'b0;

    always #5 i_clk = ~i_clk;

    morton_cell_hash_top dut (.*);

    morton_cell_hash_checker chk (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_in_valid(i_valid), .i_in_stall(o_stall),
        .i_pos_x, .i_pos_y, .i_pos_z,
        .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_bucket(o_bucket), .i_clamped(o_clamped),
        .o_errors(errors), .o_pending(pending), .o_results(results),
        .o_clamp_hits(clamp_hits)
    );

    // Receiver stall pattern: quiet stretches and choppy stretches.
    always @(negedge i_clk) begin
        if ($urandom_range(0, 99) == 0) stall_mode <= ~stall_mode;
        i_stall <= stall_mode ? ($urandom_range(0, 2) == 0) : 1'b0;
    end

    // Watchdog on cycles with no accepted word.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n || i_cfg_we ||
            (stim_done && pending == 0))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("morton_cell_hash_top_tb: FAIL");
            $finish;
        end
    end

    task automatic write_reg(input logic idx, input logic [CELL_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Present one position and hold it until taken; leaves valid high.
    task automatic send_position(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                                 input logic [POS_W-1:0] z);
        i_valid <= 1'b1;
        i_pos_x <= x;
        i_pos_y <= y;
        i_pos_z <= z;
        do @(posedge i_clk); while (o_stall);
        sent++;
        @(negedge i_clk);
    endtask

    task automatic pause_sender(input int cycles);
        i_valid <= 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    task automatic drain_pipe();
        pause_sender(1);
        while (pending != 0) @(negedge i_clk);
        repeat (PIPE_CYCLES + 10) @(negedge i_clk);
    endtask

    function automatic logic [POS_W-1:0] pick_coord();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000 + $urandom_range(0, 3);
            1: return 32'h7fff_ffff - $urandom_range(0, 3);
            2: return 32'($urandom_range(0, 1 << 20)) - 32'd524288;
            default: return $urandom;
        endcase
    endfunction

    // Bursty random positions.
    task automatic random_phase(input int count);
        int left;
        left = count;
        while (left > 0) begin
            int burst;
            burst = $urandom_range(1, 20);
            for (int k = 0; k < burst && left > 0; k++, left--)
                send_position(pick_coord(), pick_coord(), pick_coord());
            if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 6));
        end
    endtask

    initial begin
        logic [CELL_W-1:0]  cells[6];
        logic [TABLE_W-1:0] tables[6];
        cells  = '{CELL_W'(65536), CELL_W'(0), CELL_W'(1), CELL_W'(31'h7fff_ffff),
                   CELL_W'(3000), CELL_W'(1 << 20)};
        tables = '{TABLE_W'(65536), TABLE_W'(0), TABLE_W'(25'h1ff_ffff),
                   TABLE_W'(16777216), TABLE_W'(1), TABLE_W'(1000003)};
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: reset settings, field extremes and floor edges.
        send_position(32'h0, 32'h0, 32'h0);
        send_position(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_position(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_position(32'hffff_ffff, 32'h1, 32'hffff_0000);
        send_position(32'h0001_0000, 32'hfffe_ffff, 32'h7fff_ffff);
        pause_sender(3);
        send_position(32'hffff_ffff, 32'h0, 32'h0);
        drain_pipe();

        // Zero cell size acts as one: large indexes clamp both ways.
        write_reg(CFG_CELL_SIZE, '0);
        write_reg(CFG_TABLE_SIZE, '0);
        send_position(32'h0010_0000, 32'hfff0_0000, 32'h000f_ffff);
        send_position(32'hffef_ffff, 32'hfff0_0000, 32'h0);
        send_position(32'h0, 32'h1, 32'hffff_ffff);
        drain_pipe();
        write_reg(CFG_CELL_SIZE, 31'h7fff_ffff);
        write_reg(CFG_TABLE_SIZE, CELL_W'(25'h1ff_ffff));
        send_position(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
        send_position(32'h7fff_fffe, 32'h8000_0001, 32'h0);
        drain_pipe();
        write_reg(CFG_CELL_SIZE, CELL_W'(1));
        write_reg(CFG_TABLE_SIZE, CELL_W'(16777216));
        send_position(32'h000f_ffff, 32'hfff0_0000, 32'h0010_0000);
        send_position(32'hfff0_0001, 32'h000f_fffe, 32'h5555_aaaa);
        drain_pipe();

        // Random phases over a spread of settings, extremes included.
        for (int ph = 0; ph < 12; ph++) begin
            write_reg(CFG_CELL_SIZE, ph < 6 ? cells[ph] : CELL_W'($urandom));
            write_reg(CFG_TABLE_SIZE, ph < 6 ? CELL_W'(tables[ph]) :
                                               CELL_W'(TABLE_W'($urandom)));
            random_phase(90);
            drain_pipe();
        end
        stim_done <= 1'b1;
        repeat (5) @(negedge i_clk);

        $display("Covered %0d positions, %0d results (%0d clamped), 16 register settings.",
                 sent, results, clamp_hits);
        if (errors == 0 && pending == 0)
            $display("morton_cell_hash_top_tb: PASS");
        else
            $display("morton_cell_hash_top_tb: FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/mch_pkg.sv
hw/rtl/mch_div_cell.sv
hw/rtl/mch_mod_cell.sv
hw/rtl/mch_mix.sv
hw/rtl/morton_cell_hash_top.sv
hw/rtl/mch_checker.sv
sim/morton_cell_hash_checker.sv
sim/morton_cell_hash_top_tb.sv
